### hw/rtl/lfbt_pkg.sv
// lfbt_pkg: shared types and constants for the link failure blacklist table.
// Request/response payload structs, action codes and counter limits.
// No dependencies.
`timescale 1ns / 1ps

package lfbt_pkg;

   // table geometry and field widths
   localparam int ENTRIES_DEFAULT = 16;
   localparam int ADDR_W          = 48;
   localparam int TIME_W          = 32;
   localparam int COUNT_W         = 8;
   localparam int REC_W           = 20;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'hFF;
   localparam logic [REC_W-1:0]   REC_TIME_RST  = 20'd21600;

   // register byte addresses
   localparam logic [CSR_ADDR_W-1:0] CSR_RECOVER_TIME = 2'd0;

   // request action codes
   typedef enum logic [1:0] {
      ACT_QUERY = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_FAIL  = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0]        action;
      logic [ADDR_W-1:0] station_addr;
      logic [TIME_W-1:0] now_sec;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] fail_count;
      logic               table_full;
   } rsp_type;

endpackage

### hw/rtl/link_failure_blacklist_table.sv
// Link failure blacklist table: failure counters keyed by 48-bit station address.
// A taken request is captured in the request register; its response is strobed
// from the response register. Throughput: one request per cycle, busy never rises;
// the parallel address match and counter update fit between the request register
// and the response register. The receiver cannot stall.
// Reset (synchronous): all entries invalid, recovery time 21600 s. Uses lfbt_pkg.
`timescale 1ns / 1ps

module link_failure_blacklist_table #(
   parameter int ENTRIES = lfbt_pkg::ENTRIES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  lfbt_pkg::req_type                   req_payload,
   // response channel
   output logic                                rsp_valid,
   output lfbt_pkg::rsp_type                   rsp_payload,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lfbt_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [lfbt_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [lfbt_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   import lfbt_pkg::*;

   // configuration
   logic [REC_W-1:0]   rec_time_ff;

   // request register
   logic               req_vld_ff;
   req_type            req_ff;

   // table storage
   logic [ENTRIES-1:0] valid_ff;
   logic [ADDR_W-1:0]  addr_ff  [ENTRIES];
   logic [COUNT_W-1:0] fails_ff [ENTRIES];
   logic [TIME_W-1:0]  stamp_ff [ENTRIES];

   // response register
   logic               rsp_vld_ff;
   rsp_type            rsp_ff;

   // lookup and update
   logic [ENTRIES-1:0] hit_vec;
   logic [ENTRIES-1:0] free_vec;
   logic [ENTRIES-1:0] free_oh;
   logic [ENTRIES-1:0] sel_oh;
   logic               hit;
   logic               full;
   logic               do_write;
   logic [COUNT_W-1:0] hit_fails;
   logic [TIME_W-1:0]  hit_stamp;
   logic [COUNT_W-1:0] cur_fails;
   logic [TIME_W-1:0]  cur_stamp;
   logic [TIME_W-1:0]  elapsed;
   logic [COUNT_W-1:0] fails_in;
   logic [TIME_W-1:0]  stamp_in;
   rsp_type            rsp_in;

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign prdata = {{(CSR_DATA_W-REC_W){1'b0}}, rec_time_ff};

   // config register write
   always_ff @(posedge clock) begin
      if (reset) begin
         rec_time_ff <= REC_TIME_RST;
      end else if (psel && penable && pwrite && paddr == CSR_RECOVER_TIME) begin
         rec_time_ff <= pwdata[REC_W-1:0];
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_payload;
      end
   end

   // parallel match and free-slot vectors
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i]  = valid_ff[i] && (addr_ff[i] == req_ff.station_addr);
         free_vec[i] = !valid_ff[i];
      end
   end

   // lowest free slot as one-hot
   assign free_oh = free_vec & (~free_vec + {{(ENTRIES-1){1'b0}}, 1'b1});
   assign hit     = |hit_vec;
   assign full    = !hit && !(|free_vec);
   assign sel_oh  = hit ? hit_vec : free_oh;

   // one-hot read of the matching entry
   always_comb begin
      hit_fails = '0;
      hit_stamp = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_fails = hit_fails | (fails_ff[i] & {COUNT_W{hit_vec[i]}});
         hit_stamp = hit_stamp | (stamp_ff[i] & {TIME_W{hit_vec[i]}});
      end
   end

   // a fresh entry starts at zero, stamped now
   assign cur_fails = hit ? hit_fails : '0;
   assign cur_stamp = hit ? hit_stamp : req_ff.now_sec;
   assign elapsed   = req_ff.now_sec - cur_stamp;

   // counter update per action
   always_comb begin
      fails_in = cur_fails;
      stamp_in = cur_stamp;
      case (action_type'(req_ff.action))
         ACT_QUERY: begin
            if (cur_fails != '0 && elapsed > {{(TIME_W-REC_W){1'b0}}, rec_time_ff}) begin
               fails_in = cur_fails - 8'd1;
               stamp_in = req_ff.now_sec;
            end
         end
         ACT_CLEAR: begin
            fails_in = '0;
            stamp_in = req_ff.now_sec;
         end
         ACT_FAIL: begin
            if (cur_fails != COUNT_MAX) begin
               fails_in = cur_fails + 8'd1;
            end
            stamp_in = req_ff.now_sec;
         end
         default: begin
            fails_in = cur_fails;
            stamp_in = cur_stamp;
         end
      endcase
   end

   assign do_write = req_vld_ff && (action_type'(req_ff.action) != ACT_NOP) && !full;

   // response value
   always_comb begin
      rsp_in.fail_count = fails_in;
      rsp_in.table_full = 1'b0;
      if (action_type'(req_ff.action) == ACT_NOP) begin
         rsp_in.fail_count = '0;
      end else if (full) begin
         rsp_in.fail_count = COUNT_MAX;
         rsp_in.table_full = 1'b1;
      end
   end

   // table valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (do_write) begin
         valid_ff <= valid_ff | sel_oh;
      end
   end

   // table payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (do_write && sel_oh[i]) begin
            addr_ff[i]  <= req_ff.station_addr;
            fails_ff[i] <= fails_in;
            stamp_ff[i] <= stamp_in;
         end
      end
   end

   // response strobe and data
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= req_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_vld_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

   // an address is held in at most one slot
   a_hit_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("station address matched more than one slot");

   // every taken request gets a response strobe
   a_rsp_timing: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("response strobe missing for a taken request");

   // a full report means no free slot remained
   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.table_full) |-> (&valid_ff))
      else $error("table full reported with a free slot");

   // a full report always carries the saturated count
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.table_full) |-> (rsp_payload.fail_count == COUNT_MAX))
      else $error("table full response without saturated count");

   // the table only grows by one slot per request
   a_grow_one: assert property (@(posedge clock) disable iff (reset)
      req_vld_ff |=> ($countones(valid_ff) <= $countones($past(valid_ff)) + 1))
      else $error("more than one slot allocated by a request");

endmodule

### verif/testbench.sv
// testbench: self-checking bench for link_failure_blacklist_table.
// Drives requests and APB writes, predicts every response in-bench, compares field by field.
// Depends on lfbt_pkg and link_failure_blacklist_table.
`timescale 1ns / 1ps

module testbench;
   import lfbt_pkg::*;

   localparam int ENTRIES   = ENTRIES_DEFAULT;
   localparam int POOL_SIZE = 20;
   localparam int LATENCY   = 2;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_payload;
   logic              rsp_valid;
   rsp_type           rsp_payload;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic              pready;

   // shadow of the table and its recovery setting
   logic              tbl_valid [ENTRIES];
   logic [ADDR_W-1:0] tbl_addr  [ENTRIES];
   logic [COUNT_W-1:0] tbl_fails [ENTRIES];
   logic [TIME_W-1:0] tbl_stamp [ENTRIES];
   logic [REC_W-1:0]  recover_sec;

   // responses still owed by the block, oldest first
   rsp_type           pending_counts [$];

   // stimulus state
   logic [ADDR_W-1:0] station_pool [POOL_SIZE];
   logic [TIME_W-1:0] wall_sec;
   bit                gaps_on;

   int                n_errors;
   int                n_requests;
   int                n_settings;
   int                n_full;
   int                n_forgiven;

   link_failure_blacklist_table #(.ENTRIES(ENTRIES)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // table prediction: lookup, insert on miss, then apply the action
   function automatic rsp_type apply_table_request(req_type r);
      rsp_type          res;
      int               slot;
      logic [TIME_W-1:0] elapsed;
      res  = '0;
      slot = -1;
      if (action_type'(r.action) == ACT_NOP)
         return res;
      for (int i = 0; i < ENTRIES; i++)
         if (slot < 0 && tbl_valid[i] && tbl_addr[i] == r.station_addr)
            slot = i;
      if (slot < 0) begin
         for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && !tbl_valid[i])
               slot = i;
         if (slot < 0) begin
            res.fail_count = COUNT_MAX;
            res.table_full = 1'b1;
            n_full++;
            return res;
         end
         tbl_valid[slot] = 1'b1;
         tbl_addr[slot]  = r.station_addr;
         tbl_fails[slot] = '0;
         tbl_stamp[slot] = r.now_sec;
      end
      case (action_type'(r.action))
         ACT_QUERY: begin
            elapsed = r.now_sec - tbl_stamp[slot];
            if (tbl_fails[slot] != 0 && elapsed > TIME_W'(recover_sec)) begin
               tbl_fails[slot] = tbl_fails[slot] - 8'd1;
               tbl_stamp[slot] = r.now_sec;
               n_forgiven++;
            end
         end
         ACT_CLEAR: begin
            tbl_fails[slot] = '0;
            tbl_stamp[slot] = r.now_sec;
         end
         default: begin
            if (tbl_fails[slot] != COUNT_MAX)
               tbl_fails[slot] = tbl_fails[slot] + 8'd1;
            tbl_stamp[slot] = r.now_sec;
         end
      endcase
      res.fail_count = tbl_fails[slot];
      return res;
   endfunction

   // response checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_counts.size() == 0) begin
            $error("unexpected response: fail_count %0d table_full %0d",
                   rsp_payload.fail_count, rsp_payload.table_full);
            n_errors++;
         end else begin
            want = pending_counts.pop_front();
            if (rsp_payload.fail_count !== want.fail_count) begin
               $error("fail_count expected %0d actual %0d",
                      want.fail_count, rsp_payload.fail_count);
               n_errors++;
            end
            if (rsp_payload.table_full !== want.table_full) begin
               $error("table_full expected %0d actual %0d",
                      want.table_full, rsp_payload.table_full);
               n_errors++;
            end
         end
      end
   end

   // one request; leaves start high unless a gap is drawn
   // (an idle gap follows about a fifth of requests: ~31% idle)
   task automatic send_request(input action_type act, input logic [ADDR_W-1:0] station,
                               input logic [TIME_W-1:0] now);
      req_type r;
      r.action       = act;
      r.station_addr = station;
      r.now_sec      = now;
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      pending_counts.push_back(apply_table_request(r));
      n_requests++;
      if (gaps_on && $urandom_range(0, 99) < 22) begin
         start       <= 1'b0;
         req_payload <= req_type'({$urandom, $urandom, $urandom});
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // drain outstanding responses before touching the register
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_counts.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 1) @(posedge clock);
   endtask

   // APB write of the recovery time, then read back
   task automatic set_recover_time(input logic [REC_W-1:0] value);
      logic [CSR_DATA_W-1:0] word;
      word = {$urandom} ;
      word[REC_W-1:0] = value;
      wait_idle();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_RECOVER_TIME;
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      recover_sec = value;
      n_settings++;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DATA_W'(value)) begin
         $error("recover_time_sec expected %0d actual %0d", value, prdata);
         n_errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // advance the stimulus clock: mostly small steps, some near the window, a few jumps
   function automatic logic [TIME_W-1:0] next_wall_sec();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         wall_sec = wall_sec + $urandom_range(0, 8);
      else if (pick < 90)
         wall_sec = wall_sec + $urandom_range(0, 2 * int'(recover_sec) + 2);
      else
         wall_sec = $urandom;
      return wall_sec;
   endfunction

   // hand-picked cases: extremes, every action, wrap of elapsed time, zero bytes in keys
   task automatic test_directed();
      send_request(ACT_QUERY, 48'h0, 32'h0);
      send_request(ACT_FAIL, 48'h0, 32'h0);
      send_request(ACT_FAIL, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      // elapsed wraps through zero to one past the window
      send_request(ACT_QUERY, 48'hFFFF_FFFF_FFFF, 32'd21600);
      // exactly at the window: kept
      send_request(ACT_QUERY, 48'h0, 32'd21600);
      send_request(ACT_QUERY, 48'h0, 32'd21601);
      send_request(ACT_QUERY, 48'h0, 32'd90000);
      send_request(ACT_FAIL, 48'h0, 32'd90001);
      send_request(ACT_FAIL, 48'h0, 32'd90002);
      send_request(ACT_CLEAR, 48'h0, 32'd90003);
      // clear and failure on a miss insert the key first
      send_request(ACT_CLEAR, 48'h0123_4567_89AB, 32'h8000_0000);
      send_request(ACT_FAIL, 48'hFEDC_BA98_7654, 32'h7FFF_FFFF);
      send_request(ACT_NOP, 48'h0, 32'h0);
      send_request(ACT_NOP, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      // keys sharing zero bytes must still compare on all six bytes
      send_request(ACT_FAIL, 48'h0011_2233_4400, 32'd5);
      send_request(ACT_FAIL, 48'h0011_2233_4400, 32'd6);
      send_request(ACT_QUERY, 48'h0055_6677_8800, 32'd7);
      send_request(ACT_QUERY, 48'h0011_2233_4400, 32'd8);
   endtask

   // failure count saturates at its maximum and keeps stamping
   task automatic test_saturation();
      for (int i = 0; i < 258; i++)
         send_request(ACT_FAIL, station_pool[3], wall_sec + i);
      send_request(ACT_QUERY, station_pool[3], wall_sec + 300);
      wall_sec = wall_sec + 400;
   endtask

   // random traffic under several recovery settings, extremes included
   task automatic test_random_traffic();
      logic [REC_W-1:0] settings [7];
      logic [ADDR_W-1:0] station;
      action_type        act;
      int                pick;
      settings = '{20'd0, 20'd1, 20'd7, 20'd40, 20'hFFFFF, 20'd21600, 20'd0};
      settings[6] = REC_W'($urandom_range(0, 3000));
      for (int ph = 0; ph < 7; ph++) begin
         set_recover_time(settings[ph]);
         gaps_on = (ph != 3);
         for (int n = 0; n < 236; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
               station = station_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (pick < 95)
               station = ADDR_W'({$urandom, $urandom});
            else
               station = station_pool[$urandom_range(0, POOL_SIZE - 1)]
                         ^ (48'h1 << $urandom_range(0, ADDR_W - 1));
            pick = $urandom_range(0, 99);
            if (pick < 40)
               act = ACT_QUERY;
            else if (pick < 80)
               act = ACT_FAIL;
            else if (pick < 95)
               act = ACT_CLEAR;
            else
               act = ACT_NOP;
            send_request(act, station, next_wall_sec());
         end
      end
      gaps_on = 1'b1;
   endtask

   // fill any free slots, then miss with every action; hits keep working
   task automatic test_table_full();
      int used;
      used = 0;
      for (int i = 0; i < ENTRIES; i++)
         if (tbl_valid[i])
            used++;
      for (int i = used; i < ENTRIES; i++)
         send_request(ACT_FAIL, ADDR_W'({$urandom, $urandom}), next_wall_sec());
      send_request(ACT_QUERY, ADDR_W'({$urandom, $urandom}), next_wall_sec());
      send_request(ACT_CLEAR, ADDR_W'({$urandom, $urandom}), next_wall_sec());
      send_request(ACT_FAIL, ADDR_W'({$urandom, $urandom}), next_wall_sec());
      send_request(ACT_NOP, ADDR_W'({$urandom, $urandom}), next_wall_sec());
      send_request(ACT_FAIL, tbl_addr[0], next_wall_sec());
      send_request(ACT_QUERY, tbl_addr[ENTRIES - 1], next_wall_sec());
   endtask

   // main sequence
   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      n_errors    = 0;
      n_requests  = 0;
      n_settings  = 0;
      n_full      = 0;
      n_forgiven  = 0;
      gaps_on     = 1'b1;
      wall_sec    = 32'hFFFF_F000;
      recover_sec = REC_TIME_RST;
      for (int i = 0; i < ENTRIES; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_addr[i]  = '0;
         tbl_fails[i] = '0;
         tbl_stamp[i] = '0;
      end
      station_pool[0] = 48'h0;
      station_pool[1] = 48'hFFFF_FFFF_FFFF;
      station_pool[2] = 48'h0011_2233_4400;
      for (int i = 3; i < POOL_SIZE; i++)
         station_pool[i] = ADDR_W'({$urandom, $urandom});

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_saturation();
      test_random_traffic();
      test_table_full();

      wait_idle();
      $display("Sent %0d requests over %0d recovery settings.", n_requests, n_settings);
      $display("Saw %0d table-full misses and %0d forgiven failures.", n_full, n_forgiven);
      if (n_errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### link_failure_blacklist_table.f
hw/rtl/lfbt_pkg.sv
hw/rtl/link_failure_blacklist_table.sv
verif/testbench.sv
